>>> rtl/snapshot_double_buffer_top_macros.svh
// ----------------------------------------------------------------------------
// snapshot double buffer assertion macros
// shared property shapes, clocked on clk_i and disabled in reset
// ----------------------------------------------------------------------------
`ifndef SNAPSHOT_DOUBLE_BUFFER_TOP_MACROS_SVH
`define SNAPSHOT_DOUBLE_BUFFER_TOP_MACROS_SVH

// same-cycle implication
`define SDB_ASSERT_IMP(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define SDB_ASSERT_NXT(name, ante, cons, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> rtl/sdb_pkg.sv
// ----------------------------------------------------------------------------
// sdb_pkg
// types, constants and codes shared by the snapshot double buffer
// ----------------------------------------------------------------------------
package sdb_pkg;

  localparam int CHANNELS = 16;
  localparam int SLOTS    = 2;

  localparam int SLOT_W = $clog2(SLOTS);
  localparam int POS_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int ADDR_W = $clog2(SLOTS * CHANNELS);

  typedef enum logic [1:0] {
    FUNC_PUBLISH = 2'd0,
    FUNC_ACQUIRE = 2'd1,
    FUNC_RELEASE = 2'd2,
    FUNC_NOP     = 2'd3
  } func_e;

  typedef enum logic [1:0] {
    MARK_FREE    = 2'd0,
    MARK_WRITING = 2'd1,
    MARK_READY   = 2'd2,
    MARK_READING = 2'd3
  } mark_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_SEND
  } state_e;

  typedef struct packed {
    logic [1:0]  func;
    logic [15:0] sample;
    logic        slot;
  } in_item_t;

  typedef struct packed {
    logic        found;
    logic        slot_taken;
    logic [15:0] value;
    logic        last;
    logic [31:0] drops;
  } out_item_t;

  // controller to datapath
  typedef struct packed {
    logic pub;      // store one publish sample
    logic rel;      // release the requested slot
    logic acq;      // take the lowest ready slot
    logic miss;     // acquire with nothing ready
    logic rd;       // read one stored sample
    logic rd_next;  // advance the readout position
  } sdb_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic ready_found;
    logic rd_last;
  } sdb_status_t;

endpackage

>>> rtl/sdb_datapath.sv
// ----------------------------------------------------------------------------
// sdb_datapath
// slot marks, sample store, publish framing, drop counter and readout
// ----------------------------------------------------------------------------
`include "snapshot_double_buffer_top_macros.svh"

module sdb_datapath (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  sdb_pkg::sdb_cmd_t   cmd_i,
  input  sdb_pkg::in_item_t   in_data_i,
  output sdb_pkg::sdb_status_t status_o,
  output sdb_pkg::out_item_t  out_data_o
);
  import sdb_pkg::*;

  mark_e              mark_q [SLOTS];
  mark_e              mark_d [SLOTS];
  logic [SLOT_W-1:0]  wslot_q, wslot_d;
  logic [POS_W-1:0]   wpos_q, wpos_d;
  logic               disc_q, disc_d;
  logic [31:0]        drops_q, drops_d;

  logic [SLOT_W-1:0]  rd_slot_q;
  logic [POS_W-1:0]   rd_pos_q;
  logic               found_q;
  logic [15:0]        rdata_q;

  logic [15:0]        mem [SLOTS*CHANNELS];

  logic               free_found, ready_found;
  logic [SLOT_W-1:0]  free_slot, ready_slot;
  logic               frame_start, frame_end, eff_disc;
  logic [SLOT_W-1:0]  eff_slot, rel_slot;
  logic               wr_en;
  logic [ADDR_W-1:0]  wr_addr, rd_addr;
  logic [SLOTS-1:0]   writing_vec;

  // lowest free and lowest ready slot
  always_comb begin
    free_found  = 1'b0;
    ready_found = 1'b0;
    free_slot   = '0;
    ready_slot  = '0;
    for (int i = SLOTS - 1; i >= 0; i--) begin
      if (mark_q[i] == MARK_FREE) begin
        free_found = 1'b1;
        free_slot  = SLOT_W'(i);
      end
      if (mark_q[i] == MARK_READY) begin
        ready_found = 1'b1;
        ready_slot  = SLOT_W'(i);
      end
    end
  end

  assign frame_start = (wpos_q == '0);
  assign frame_end   = (int'(wpos_q) == CHANNELS - 1);
  assign eff_disc    = frame_start ? !free_found : disc_q;
  assign eff_slot    = (frame_start && free_found) ? free_slot : wslot_q;
  assign rel_slot    = SLOT_W'(in_data_i.slot);
  assign wr_en       = cmd_i.pub && !eff_disc;
  assign wr_addr     = ADDR_W'(int'(eff_slot) * CHANNELS + int'(wpos_q));
  assign rd_addr     = ADDR_W'(int'(rd_slot_q) * CHANNELS + int'(rd_pos_q));

  always_comb begin
    mark_d  = mark_q;
    wslot_d = wslot_q;
    wpos_d  = wpos_q;
    disc_d  = disc_q;
    drops_d = drops_q;
    if (cmd_i.pub) begin
      if (frame_start) begin
        disc_d = !free_found;
        if (free_found) begin
          mark_d[free_slot] = MARK_WRITING;
          wslot_d           = free_slot;
        end else begin
          drops_d = drops_q + 32'd1;
        end
      end
      if (frame_end) begin
        if (!eff_disc) begin
          mark_d[eff_slot] = MARK_READY;
        end
        wpos_d = '0;
        disc_d = 1'b0;
      end else begin
        wpos_d = wpos_q + POS_W'(1);
      end
    end
    if (cmd_i.rel && int'(in_data_i.slot) < SLOTS && mark_q[rel_slot] != MARK_WRITING) begin
      mark_d[rel_slot] = MARK_FREE;
    end
    if (cmd_i.acq) begin
      mark_d[ready_slot] = MARK_READING;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < SLOTS; i++) begin
        mark_q[i] <= MARK_FREE;
      end
      wslot_q   <= '0;
      wpos_q    <= '0;
      disc_q    <= 1'b0;
      drops_q   <= '0;
      rd_slot_q <= '0;
      rd_pos_q  <= '0;
      found_q   <= 1'b0;
    end else begin
      mark_q  <= mark_d;
      wslot_q <= wslot_d;
      wpos_q  <= wpos_d;
      disc_q  <= disc_d;
      drops_q <= drops_d;
      if (cmd_i.acq) begin
        rd_slot_q <= ready_slot;
        rd_pos_q  <= '0;
        found_q   <= 1'b1;
      end else if (cmd_i.miss) begin
        found_q <= 1'b0;
      end else if (cmd_i.rd_next) begin
        rd_pos_q <= rd_pos_q + POS_W'(1);
      end
    end
  end

  // sample store, one write and one registered read port
  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= in_data_i.sample;
    end
    if (cmd_i.rd) begin
      rdata_q <= mem[rd_addr];
    end
  end

  assign status_o.ready_found = ready_found;
  assign status_o.rd_last     = !found_q || (int'(rd_pos_q) == CHANNELS - 1);

  assign out_data_o.found      = found_q;
  assign out_data_o.slot_taken = found_q ? rd_slot_q[0] : 1'b0;
  assign out_data_o.value      = found_q ? rdata_q : 16'd0;
  assign out_data_o.last       = status_o.rd_last;
  assign out_data_o.drops      = drops_q;

  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      writing_vec[i] = (mark_q[i] == MARK_WRITING);
    end
  end

  `SDB_ASSERT_IMP(a_one_writer, 1'b1, $onehot0(writing_vec), "more than one slot writing")
  `SDB_ASSERT_IMP(a_frame_owner, (wpos_q != '0) && !disc_q, mark_q[wslot_q] == MARK_WRITING, "open frame without writing slot")
  `SDB_ASSERT_NXT(a_drops_step, 1'b1, (drops_q == $past(drops_q)) || (drops_q == $past(drops_q) + 32'd1), "drop counter jumped")

endmodule

>>> rtl/sdb_ctrl.sv
// ----------------------------------------------------------------------------
// sdb_ctrl
// request decode and acquire readout sequencing
// ----------------------------------------------------------------------------
module sdb_ctrl (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 in_valid_i,
  input  logic [1:0]           in_func_i,
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  input  sdb_pkg::sdb_status_t status_i,
  output sdb_pkg::sdb_cmd_t    cmd_o
);
  import sdb_pkg::*;

  state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    in_stall_o  = 1'b1;
    out_valid_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          case (in_func_i)
            FUNC_PUBLISH: cmd_o.pub = 1'b1;
            FUNC_RELEASE: cmd_o.rel = 1'b1;
            FUNC_ACQUIRE: begin
              if (status_i.ready_found) begin
                cmd_o.acq = 1'b1;
                state_d   = ST_READ;
              end else begin
                cmd_o.miss = 1'b1;
                state_d    = ST_SEND;
              end
            end
            default: ;
          endcase
        end
      end
      ST_READ: begin
        cmd_o.rd = 1'b1;
        state_d  = ST_SEND;
      end
      ST_SEND: begin
        out_valid_o = 1'b1;
        if (!out_stall_i) begin
          if (status_i.rd_last) begin
            state_d = ST_IDLE;
          end else begin
            cmd_o.rd_next = 1'b1;
            state_d       = ST_READ;
          end
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

endmodule

>>> rtl/snapshot_double_buffer_top.sv
// ----------------------------------------------------------------------------
// snapshot_double_buffer_top
// ping-pong snapshot exchange between a sampler and a consumer
// ----------------------------------------------------------------------------
// Two slots carry a free, writing, ready or reading mark. A publish frame is
// CHANNELS publish requests; its first sample claims the lowest free slot, or
// the whole frame is dropped and the 32-bit drop count steps by one. Acquire
// takes the lowest ready slot and returns its CHANNELS samples with last on
// the final one, or a single not-found result. Release frees a slot unless it
// is being written. Publish, release and no-op requests leave the controller idle.
// A hit acquire runs the accept in idle, then for every sample a read state
// through the registered read port of the sample store and a send state that
// waits out output stall; a miss goes from the accept straight to the send state.
// Input is stalled while results are out.
// The sample store needs no clearing after reset.
// ----------------------------------------------------------------------------
module snapshot_double_buffer_top (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  sdb_pkg::in_item_t  in_data_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output sdb_pkg::out_item_t out_data_o
);
  import sdb_pkg::*;

  // command and status between the two halves
  sdb_cmd_t    cmd;
  sdb_status_t status;

  // request decode and readout sequencing
  sdb_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_func_i   (in_data_i.func),
    .in_stall_o  (in_stall_o),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_i    (status),
    .cmd_o       (cmd)
  );

  // marks, store, framing and drop count
  sdb_datapath u_datapath (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .in_data_i  (in_data_i),
    .status_o   (status),
    .out_data_o (out_data_o)
  );

endmodule
